FILE: sv/swtm_pkg.sv
// swtm_pkg: shared types and constants of the sliding window throughput meter
// used by sliding_window_throughput_meter_top and swtm_chk, no dependencies
package swtm_pkg;

   localparam int FIFO_DEPTH = 256;
   localparam logic [63:0] WINDOW_NS = 64'd100000000;

   localparam int STAMP_W = 64;
   localparam int SIZE_W = 22;
   localparam int TPUT_W = 24;
   localparam int HELD_W = 9;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W = PTR_W + SIZE_W;

   // throughput x100 = round(byte_sum * 800000 / WINDOW_NS), reduced by a common factor
   localparam int RATE_SCALE = 800000;
   localparam int TPUT_GCD = 400000;
   localparam int TPUT_NUM = RATE_SCALE / TPUT_GCD;
   localparam int TPUT_DEN = int'(WINDOW_NS / TPUT_GCD);
   localparam int TPUT_BIAS = int'((WINDOW_NS / 2) / TPUT_GCD);

   // reciprocal divide: q0 = (x * RECIP) >> X_W is q or q - 1
   localparam int X_W = SUM_W + $clog2(TPUT_NUM) + 1;
   localparam logic [63:0] TPUT_RECIP = (64'd1 << X_W) / 64'(TPUT_DEN);
   localparam int RECIP_W = X_W - $clog2(TPUT_DEN) + 1;
   localparam int PROD_W = X_W + RECIP_W;
   localparam logic [TPUT_W-1:0] TPUT_MAX = '1;

   typedef struct packed {
      logic [STAMP_W-1:0] end_time_ns;
      logic [SIZE_W-1:0]  frame_bytes;
   } req_type;

   typedef struct packed {
      logic [TPUT_W-1:0] throughput_x100;
      logic              forced_drop;
      logic [HELD_W-1:0] entries_held;
   } rsp_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [SIZE_W-1:0]  size;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_CHECK = 2'b10
   } state_type;

endpackage

FILE: sv/sliding_window_throughput_meter_top.sv
// sliding window throughput meter: frame FIFO in one memory, running byte sum
// and a reciprocal divide pipeline; depends on swtm_pkg
// latency: req beat passes head check (held while evicting), stage 1, stage 2, result reg
// throughput: one frame at a time, req_ready only in idle with stage 1 free to move on
// reset: synchronous, clears head pointer, fill count, byte sum and pipeline valids;
// the entry memory is not cleared, only entries counted by the fill count are used
module sliding_window_throughput_meter_top
   import swtm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   entry_type mem [FIFO_DEPTH];
   entry_type rd_ff;

   state_type state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic [STAMP_W-1:0] now_ff, now_in;
   logic [STAMP_W-1:0] start_ff, start_in;
   logic [SIZE_W-1:0]  bytes_ff, bytes_in;

   logic              s1_v_ff, s1_v_in;
   logic [X_W-1:0]    x1_ff, x1_in;
   logic              drop1_ff, drop1_in;
   logic [HELD_W-1:0] held1_ff, held1_in;

   logic              s2_v_ff, s2_v_in;
   logic [PROD_W-1:0] p2_ff, p2_in;
   logic [X_W-1:0]    x2_ff;
   logic              drop2_ff;
   logic [HELD_W-1:0] held2_ff;

   logic    rsp_v_ff, rsp_v_in;
   rsp_type rsp_ff, rsp_in;

   logic accept, evict, full, push, drop;
   logic s2_load, rsp_load;
   logic [PTR_W-1:0] head_next, tail;
   logic [PTR_W:0]   tail_sum;
   entry_type        wr_entry;

   logic [RECIP_W-1:0] q0, q1;
   logic [X_W-1:0]     rem;

   assign accept = req_valid && req_ready;
   assign rsp_load = s2_v_ff && (!rsp_v_ff || rsp_ready);
   assign s2_load = s1_v_ff && (!s2_v_ff || rsp_load);
   assign req_ready = (state_ff == ST_IDLE) && (!s1_v_ff || s2_load);

   assign evict = (fill_ff != '0) && (rd_ff.stamp < start_ff);
   assign full = (fill_ff == CNT_W'(FIFO_DEPTH));
   assign push = (state_ff == ST_CHECK) && !evict;
   assign drop = push && full;

   assign head_next = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum = (PTR_W+1)'(head_ff) + (PTR_W+1)'(fill_ff);
   assign tail = (tail_sum >= (PTR_W+1)'(FIFO_DEPTH)) ?
                 PTR_W'(tail_sum - (PTR_W+1)'(FIFO_DEPTH)) : PTR_W'(tail_sum);
   assign wr_entry = '{stamp: now_ff, size: bytes_ff};

   // window start clamps at zero
   always_comb begin
      now_in = now_ff;
      bytes_in = bytes_ff;
      start_in = start_ff;
      if (accept) begin
         now_in = req_data.end_time_ns;
         bytes_in = req_data.frame_bytes;
         start_in = (req_data.end_time_ns > WINDOW_NS) ?
                    req_data.end_time_ns - WINDOW_NS : '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      sum_in = sum_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (evict) begin
               head_in = head_next;
               fill_in = fill_ff - 1'b1;
               sum_in = sum_ff - SUM_W'(rd_ff.size);
            end else if (full) begin
               head_in = head_next;
               sum_in = sum_ff - SUM_W'(rd_ff.size) + SUM_W'(bytes_ff);
               state_in = ST_IDLE;
            end else begin
               fill_in = fill_ff + 1'b1;
               sum_in = sum_ff + SUM_W'(bytes_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // entry memory, read-first, head read registered every cycle
   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail] <= wr_entry;
      end
      rd_ff <= mem[head_in];
   end

   // divide pipeline
   always_comb begin
      s1_v_in = push || (s1_v_ff && !s2_load);
      x1_in = x1_ff;
      drop1_in = drop1_ff;
      held1_in = held1_ff;
      if (push) begin
         x1_in = X_W'(sum_in) * X_W'(TPUT_NUM) + X_W'(TPUT_BIAS);
         drop1_in = drop;
         held1_in = HELD_W'(fill_in);
      end
      s2_v_in = s2_load || (s2_v_ff && !rsp_load);
      p2_in = PROD_W'(x1_ff) * PROD_W'(RECIP_W'(TPUT_RECIP));
   end

   assign q0 = RECIP_W'(p2_ff >> X_W);
   assign rem = x2_ff - X_W'(q0) * X_W'(TPUT_DEN);
   assign q1 = (rem >= X_W'(TPUT_DEN)) ? q0 + 1'b1 : q0;

   always_comb begin
      rsp_v_in = rsp_load || (rsp_v_ff && !rsp_ready);
      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in.throughput_x100 = ((RECIP_W+1)'(q1) > (RECIP_W+1)'(TPUT_MAX)) ?
                                  TPUT_MAX : TPUT_W'(q1);
         rsp_in.forced_drop = drop2_ff;
         rsp_in.entries_held = held2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         fill_ff <= '0;
         sum_ff <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
         sum_ff <= sum_in;
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      bytes_ff <= bytes_in;
      start_ff <= start_in;
      x1_ff <= x1_in;
      drop1_ff <= drop1_in;
      held1_ff <= held1_in;
      if (s2_load) begin
         p2_ff <= p2_in;
         x2_ff <= x1_ff;
         drop2_ff <= drop1_ff;
         held2_ff <= held1_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: sv/swtm_chk.sv
// swtm_chk: port-level assertions of the sliding window throughput meter,
// bound to sliding_window_throughput_meter_top; depends on swtm_pkg
module swtm_chk
   import swtm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // one frame at a time through the head check
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a req beat");

   // every result counts at least the frame just pushed
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entries_held != '0) &&
                    (rsp_data.entries_held <= HELD_W'(FIFO_DEPTH)))
      else $error("entries_held out of range");

   // a forced drop only happens with a full fifo
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.forced_drop |-> rsp_data.entries_held == HELD_W'(FIFO_DEPTH))
      else $error("forced_drop without a full fifo");

endmodule

bind sliding_window_throughput_meter_top swtm_chk u_swtm_chk (.*);
